>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a result in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

>>> hw/rtl/rlee_pkg.sv
package rlee_pkg;

  // Breathe wave table and phase accumulator geometry
  localparam int WAVE_ENTRIES = 256;
  localparam int PHASE_BITS   = 16;
  localparam int IDX_W        = $clog2(WAVE_ENTRIES);
  localparam int PROD_W       = PHASE_BITS + IDX_W;

  // Shared restoring divider
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // APB register window
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Fixed-point constants for the wave table
  localparam logic [63:0] Q28_ONE   = 64'd1 << 28;
  localparam logic [63:0] PI_Q28    = 64'd843314857;
  localparam logic [63:0] DEC8      = 64'd100000000;
  localparam logic [63:0] EINV_DEC8 = 64'd36787944;
  localparam logic [63:0] NORM_DEC8 = 64'd42545906;

  typedef enum logic [1:0] {
    MODE_STEADY  = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_BREATHE = 2'd2,
    MODE_FADE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_LEVEL = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_EFFECT   = 3'd0,
    REG_COLOR    = 3'd1,
    REG_INTERVAL = 3'd2,
    REG_PHASE    = 3'd3,
    REG_FADE     = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DIV_A,
    S_LOAD_B,
    S_DIV_B,
    S_FADE_SET,
    S_MUL,
    S_STORE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  effect_sel;
    logic [2:0]  color_sel;
    logic [15:0] interval;
    logic [15:0] phase_step;
    logic [15:0] fade_time;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_load_a;
    logic div_load_b;
    logic div_step;
    logic fade_set;
    logic mul;
    logic store;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic fade_start;
    logic need_refresh;
  } dp_status_t;

  // Color components, rows by color code, columns red, green, blue
  localparam logic [7:0] COLOR_RGB [8][3] = '{
    '{8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd52,  8'd0},
    '{8'd0,   8'd0,   8'd255},
    '{8'd255, 8'd255, 8'd0},
    '{8'd255, 8'd0,   8'd255},
    '{8'd0,   8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd0}
  };

  // Unsigned 64-bit shift-subtract quotient for the table build
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Breathe level for one table entry: (exp(cos) - 1/e) * norm * 255 in Q28,
  // evaluated at elaboration only
  function automatic logic [7:0] wave_value(input int unsigned k_in);
    logic [63:0]        k;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        pos;
    logic [63:0]        neg;
    logic [63:0]        term;
    logic [63:0]        a;
    logic [63:0]        sum;
    logic [63:0]        ex;
    logic [63:0]        dq;
    logic [63:0]        v;
    logic signed [63:0] c;
    logic signed [63:0] d;
    logic [63:0]        n;
    k = 64'(k_in);
    if (k * 2 > 64'(WAVE_ENTRIES)) k = 64'(WAVE_ENTRIES) - k;
    x = (PI_Q28 * 64'd2 * k) >> IDX_W;
    x2 = (x * x) >> 28;
    pos = Q28_ONE;
    neg = 64'd0;
    term = Q28_ONE;
    for (n = 64'd1; n <= 64'd12; n++) begin
      term = div_u64((term * x2) >> 28, (64'd2 * n - 64'd1) * (64'd2 * n));
      if (n[0]) neg = neg + term;
      else pos = pos + term;
    end
    c = $signed(pos) - $signed(neg);
    a = (c < 0) ? 64'(-c) : 64'(c);
    sum = Q28_ONE;
    term = Q28_ONE;
    for (n = 64'd1; n <= 64'd16; n++) begin
      term = div_u64((term * a) >> 28, n);
      sum = sum + term;
    end
    ex = (c < 0) ? div_u64(64'd1 << 56, sum) : sum;
    d = $signed(ex * DEC8) - $signed(EINV_DEC8 << 28);
    if (d <= 0) return 8'd0;
    dq = div_u64(64'(d), DEC8);
    v = div_u64(dq * NORM_DEC8 * 64'd255, DEC8);
    v = (v + (64'd1 << 27)) >> 28;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

endpackage

>>> hw/rtl/rlee_ifs.sv
// Request channel: one effect command per transaction
interface rlee_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_ms;
  logic [7:0]  level;

  modport source (output valid, kind, now_ms, level, input ready);
  modport sink (input valid, kind, now_ms, level, output ready);
endinterface

// Response channel: one duty snapshot per transaction
interface rlee_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_duty;
  logic [7:0] green_duty;
  logic [7:0] blue_duty;
  logic       refreshed;
  logic [7:0] brightness;
  logic [1:0] effect_mode;

  modport source (output valid, red_duty, green_duty, blue_duty, refreshed, brightness,
                  effect_mode, input ready);
  modport sink (input valid, red_duty, green_duty, blue_duty, refreshed, brightness,
                effect_mode, output ready);
endinterface

>>> hw/rtl/rlee_cfg.sv
module rlee_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rlee_pkg::ADDR_W-1:0]    paddr,
  input  logic [rlee_pkg::DATA_W-1:0]    pwdata,
  output logic [rlee_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output rlee_pkg::cfg_t                 cfg
);
  import rlee_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_EFFECT:   cfg.effect_sel <= pwdata[1:0];
        REG_COLOR:    cfg.color_sel  <= pwdata[2:0];
        REG_INTERVAL: cfg.interval   <= pwdata[15:0];
        REG_PHASE:    cfg.phase_step <= pwdata[15:0];
        REG_FADE:     cfg.fade_time  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_EFFECT:   prdata = DATA_W'(cfg.effect_sel);
      REG_COLOR:    prdata = DATA_W'(cfg.color_sel);
      REG_INTERVAL: prdata = DATA_W'(cfg.interval);
      REG_PHASE:    prdata = DATA_W'(cfg.phase_step);
      REG_FADE:     prdata = DATA_W'(cfg.fade_time);
      default:      prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/rlee_ctrl.sv
module rlee_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  rlee_pkg::dp_status_t status,
  output rlee_pkg::dp_cmd_t    cmd
);
  import rlee_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] cnt_next;
  logic                 last_step;
  logic                 out_free;

  assign last_step = (cnt == DIV_CNT_W'(DIV_W - 1));
  assign out_free  = !rsp_valid || rsp_ready;

  // State, step counter and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // Sequence one transaction through the datapath
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cnt_next = '0;
        if (status.fade_start) begin
          cmd.div_load_a = 1'b1;
          state_next     = S_DIV_A;
        end else if (status.need_refresh) begin
          state_next = S_MUL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV_A: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (last_step) state_next = S_LOAD_B;
      end
      S_LOAD_B: begin
        cmd.div_load_b = 1'b1;
        cnt_next       = '0;
        state_next     = S_DIV_B;
      end
      S_DIV_B: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (last_step) state_next = S_FADE_SET;
      end
      S_FADE_SET: begin
        cmd.fade_set = 1'b1;
        state_next   = S_OUT;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/rlee_dp.sv
module rlee_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  rlee_pkg::cfg_t       cfg,
  input  rlee_pkg::dp_cmd_t    cmd,
  input  logic [1:0]           kind_in,
  input  logic [31:0]          now_in,
  input  logic [7:0]           level_in,
  output rlee_pkg::dp_status_t status,
  output logic [7:0]           red_duty,
  output logic [7:0]           green_duty,
  output logic [7:0]           blue_duty,
  output logic                 refreshed,
  output logic [7:0]           brightness,
  output logic [1:0]           effect_mode
);
  import rlee_pkg::*;

  // Captured transaction
  kind_t       kind_r;
  logic [31:0] now_r;
  logic [7:0]  level_r;

  // Effect state
  mode_t                 mode;
  logic [2:0]            color;
  logic [7:0]            bright;
  logic                  blink_on;
  logic [PHASE_BITS-1:0] phase;
  logic [7:0]            fade_step;
  logic [31:0]           last_update;
  logic [7:0]            duty [3];
  logic                  did;

  // Refresh products and divider
  logic [15:0]      prod [3];
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W:0]   trial;

  logic [7:0]        wave_rom [WAVE_ENTRIES];
  logic [PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]  idx;
  logic [31:0]       elapsed;
  logic              expired;
  mode_t             sel_mode;

  // Breathe table built at elaboration
  for (genvar g = 0; g < WAVE_ENTRIES; g++) begin : g_wave
    localparam logic [7:0] WaveVal = wave_value(g);
    assign wave_rom[g] = WaveVal;
  end

  assign idx_prod = PROD_W'(phase) * PROD_W'(WAVE_ENTRIES);
  assign idx      = idx_prod[PHASE_BITS +: IDX_W];
  assign elapsed  = now_r - last_update;
  assign expired  = elapsed > {16'd0, cfg.interval};
  assign sel_mode = mode_t'(cfg.effect_sel);
  assign trial    = {rem, quo[DIV_W-1]} - {1'b0, divisor};

  // Tell the controller what this transaction needs
  assign status.fade_start   = (kind_r == KIND_START) && (sel_mode == MODE_FADE);
  assign status.need_refresh = ((kind_r == KIND_START) && (sel_mode == MODE_STEADY)) ||
                               ((kind_r == KIND_TICK) && (mode != MODE_STEADY) && expired);

  // Latch the incoming transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind_t'(kind_in);
      now_r   <= now_in;
      level_r <= level_in;
    end
  end

  // Effect state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_STEADY;
      color       <= '0;
      bright      <= 8'hFF;
      blink_on    <= 1'b0;
      phase       <= '0;
      fade_step   <= '0;
      last_update <= '0;
      did         <= 1'b0;
      for (int i = 0; i < 3; i++) duty[i] <= '0;
    end else begin
      if (cmd.exec) begin
        did <= 1'b0;
        case (kind_r)
          KIND_START: begin
            case (sel_mode)
              MODE_STEADY: begin
                color  <= cfg.color_sel;
                mode   <= MODE_STEADY;
                bright <= 8'hFF;
                did    <= 1'b1;
              end
              MODE_BLINK: begin
                mode     <= MODE_BLINK;
                blink_on <= 1'b1;
                color    <= cfg.color_sel;
              end
              MODE_BREATHE: begin
                mode  <= MODE_BREATHE;
                phase <= '0;
                color <= cfg.color_sel;
              end
              default: mode <= MODE_FADE;
            endcase
          end
          KIND_LEVEL: bright <= level_r;
          KIND_TICK: begin
            if (mode != MODE_STEADY && expired) begin
              last_update <= now_r;
              did         <= 1'b1;
              case (mode)
                MODE_BLINK: begin
                  bright   <= blink_on ? 8'hFF : 8'h00;
                  blink_on <= !blink_on;
                end
                MODE_BREATHE: begin
                  bright <= wave_rom[idx];
                  phase  <= phase + PHASE_BITS'(cfg.phase_step);
                end
                default: begin
                  // Fade: step brightness down, or when done drop to steady black at full brightness
                  if (bright > fade_step) begin
                    bright <= bright - fade_step;
                  end else begin
                    color  <= '0;
                    mode   <= MODE_STEADY;
                    bright <= 8'hFF;
                  end
                end
              endcase
            end
          end
          default: ;
        endcase
      end
      // Zero slices saturate the fade step
      if (cmd.fade_set) fade_step <= (divisor == '0) ? 8'hFF : quo[7:0];
      // Scale products by 1/255: (p + p/256 + 1) / 256 is exact here
      if (cmd.store) begin
        for (int i = 0; i < 3; i++) begin
          duty[i] <= 8'(({1'b0, prod[i]} + 17'(prod[i] >> 8) + 17'd1) >> 8);
        end
      end
    end
  end

  // Color times brightness
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int i = 0; i < 3; i++) prod[i] <= 16'(COLOR_RGB[color][i]) * 16'(bright);
    end
  end

  // Restoring divider: fade_time / interval, then 255 / slices
  always_ff @(posedge clk) begin
    if (cmd.div_load_a) begin
      rem     <= '0;
      quo     <= DIV_W'(cfg.fade_time);
      divisor <= DIV_W'(cfg.interval);
    end else if (cmd.div_load_b) begin
      rem     <= '0;
      quo     <= DIV_W'(8'hFF);
      divisor <= (cfg.interval == '0) ? '0 : quo;
    end else if (cmd.div_step) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-2:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_duty    <= duty[0];
      green_duty  <= duty[1];
      blue_duty   <= duty[2];
      refreshed   <= did;
      brightness  <= bright;
      effect_mode <= mode;
    end
  end

endmodule

>>> hw/rtl/rgb_led_effect_engine.sv
// RGB LED effect engine: steady, blink, breathe and fade.
// The req channel carries one command per transaction: a time tick with
// now_ms, a start of the effect held in the configuration registers, or a
// new brightness level. Every request yields exactly one transaction on rsp
// with the three PWM duties, the brightness, the active effect and a flag
// that is set when the duties were recomputed.
// Registers are written over APB (pready is always high) by the user only
// while idle; the block itself does not enforce it. A request is captured,
// then executed; an item that does not recompute duties goes on to the
// output register, a recompute first multiplies, then scales by 1/255, and a
// fade start first runs two 16-step passes of the shared bit-serial divider.
// req.ready is high only while the engine waits for a request.
// A finished response sits in the output register; the next request is
// taken while it waits, but its own response holds until rsp.ready frees it.
// Synchronous reset rst: steady mode, black, brightness 255, duties 0,
// all configuration registers 0.
`include "assert_macros.svh"

module rgb_led_effect_engine (
  input  logic                        clk,
  input  logic                        rst,
  rlee_req_if.sink                    req,
  rlee_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlee_pkg::ADDR_W-1:0] paddr,
  input  logic [rlee_pkg::DATA_W-1:0] pwdata,
  output logic [rlee_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rlee_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  rlee_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlee_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rlee_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .kind_in     (req.kind),
    .now_in      (req.now_ms),
    .level_in    (req.level),
    .status      (status),
    .red_duty    (rsp.red_duty),
    .green_duty  (rsp.green_duty),
    .blue_duty   (rsp.blue_duty),
    .refreshed   (rsp.refreshed),
    .brightness  (rsp.brightness),
    .effect_mode (rsp.effect_mode)
  );

  // One request in flight at a time
  `ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready, "second request taken")
  // A refresh that lands in steady mode always runs at full brightness
  `ASSERT_ALWAYS(a_steady_full, clk, rst, !(rsp.valid && rsp.refreshed && rsp.effect_mode == MODE_STEADY) || rsp.brightness == 8'hFF, "steady refresh below full")
  // Blink refreshes only ever switch fully on or fully off
  `ASSERT_ALWAYS(a_blink_level, clk, rst, !(rsp.valid && rsp.refreshed && rsp.effect_mode == MODE_BLINK) || rsp.brightness == 8'h00 || rsp.brightness == 8'hFF, "blink level not on or off")

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rlee_pkg::*;

  // Breathe table geometry and fixed-point constants of the level curve
  localparam int unsigned     WAVE_N  = 256;
  localparam int unsigned     PHASE_N = 16;
  localparam longint unsigned ONE_FX  = 64'd1 << 28;
  localparam longint unsigned PI_FX   = 64'd843314857;
  localparam longint unsigned DEC_FX  = 64'd100000000;
  localparam longint unsigned EINV_FX = 64'd36787944;
  localparam longint unsigned NORM_FX = 64'd42545906;

  // One response snapshot as the engine reports it
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       refreshed;
    logic [7:0] brightness;
    mode_t      mode;
  } duty_snap_t;

  // Shadow of the engine: register copy, effect state and pending snapshots
  class led_scoreboard;
    logic [1:0]      eff_sel;
    logic [2:0]      col_sel;
    logic [15:0]     interval;
    logic [15:0]     phase_inc;
    logic [15:0]     fade_ms;
    mode_t           mode;
    logic [2:0]      color;
    logic [7:0]      bright;
    logic            blink_hi;
    logic [15:0]     phase;
    logic [7:0]      step;
    logic [31:0]     last_ms;
    logic [2:0][7:0] duty;
    logic [7:0]      breathe_lut [WAVE_N];
    duty_snap_t      expected_q [$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     recomputed;

    function new();
      for (int k = 0; k < WAVE_N; k++) breathe_lut[k] = wave_point(k);
      eff_sel    = 2'd0;
      col_sel    = 3'd0;
      interval   = 16'd0;
      phase_inc  = 16'd0;
      fade_ms    = 16'd0;
      mode       = MODE_STEADY;
      color      = 3'd0;
      bright     = 8'd255;
      blink_hi   = 1'b0;
      phase      = 16'd0;
      step       = 8'd0;
      last_ms    = 32'd0;
      duty       = '0;
      mismatches = 0;
      checked    = 0;
      recomputed = 0;
    endfunction

    // Level for one table slot: (exp(cos) - 1/e) * norm * 255, all in Q28
    function logic [7:0] wave_point(longint unsigned k);
      longint unsigned j, ang, ang2, cpos, cneg, t, mag, esum, ex_fx, q, lvl, n;
      longint signed   cval, dval;
      j = k;
      if (j * 2 > WAVE_N) j = WAVE_N - j;
      ang  = PI_FX * 2 * j / WAVE_N;
      ang2 = (ang * ang) >> 28;
      // cosine series, odd terms subtract
      cpos = ONE_FX;
      cneg = 0;
      t    = ONE_FX;
      n    = 1;
      while (n <= 12) begin
        t = ((t * ang2) >> 28) / ((2 * n - 1) * (2 * n));
        if (n % 2 == 1) cneg += t;
        else cpos += t;
        n++;
      end
      cval = $signed(cpos) - $signed(cneg);
      mag  = $unsigned(cval < 0 ? -cval : cval);
      // exponential of the magnitude, inverted for a negative cosine
      esum = ONE_FX;
      t    = ONE_FX;
      n    = 1;
      while (n <= 16) begin
        t = ((t * mag) >> 28) / n;
        esum += t;
        n++;
      end
      ex_fx = (cval < 0) ? ((64'd1 << 56) / esum) : esum;
      dval  = $signed(ex_fx * DEC_FX) - $signed(EINV_FX << 28);
      if (dval <= 0) return 8'd0;
      q   = $unsigned(dval) / DEC_FX;
      lvl = q * NORM_FX * 255 / DEC_FX;
      lvl = (lvl + (64'd1 << 27)) >> 28;
      return (lvl > 255) ? 8'd255 : lvl[7:0];
    endfunction

    function logic [23:0] rgb_of(logic [2:0] c);
      case (c)
        3'd1:    return 24'hFF_00_00;
        3'd2:    return 24'h00_34_00;
        3'd3:    return 24'h00_00_FF;
        3'd4:    return 24'hFF_FF_00;
        3'd5:    return 24'hFF_00_FF;
        3'd6:    return 24'h00_FF_FF;
        default: return 24'h00_00_00;
      endcase
    endfunction

    // Scale each color component by brightness / 255, truncated
    function void recolor();
      logic [23:0] rgb;
      rgb = rgb_of(color);
      for (int i = 0; i < 3; i++)
        duty[i] = 8'((16'(rgb[8*(2-i) +: 8]) * 16'(bright)) / 16'd255);
    endfunction

    function void go_steady(logic [2:0] c);
      color  = c;
      mode   = MODE_STEADY;
      bright = 8'd255;
      recolor();
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_EFFECT:   eff_sel   = value[1:0];
        REG_COLOR:    col_sel   = value[2:0];
        REG_INTERVAL: interval  = value[15:0];
        REG_PHASE:    phase_inc = value[15:0];
        REG_FADE:     fade_ms   = value[15:0];
        default: ;
      endcase
    endfunction

    // Advance the shadow by one accepted request and queue its snapshot
    function void note_item(kind_t k, logic [31:0] now, logic [7:0] lvl);
      duty_snap_t  want;
      logic        did;
      logic [15:0] slices;
      int unsigned idx;
      did = 1'b0;
      case (k)
        KIND_START: begin
          case (mode_t'(eff_sel))
            MODE_STEADY: begin
              go_steady(col_sel);
              did = 1'b1;
            end
            MODE_BLINK: begin
              mode     = MODE_BLINK;
              blink_hi = 1'b1;
              color    = col_sel;
            end
            MODE_BREATHE: begin
              mode  = MODE_BREATHE;
              phase = 16'd0;
              color = col_sel;
            end
            default: begin
              slices = (interval == 16'd0) ? 16'd0 : fade_ms / interval;
              step   = (slices == 16'd0) ? 8'd255 : 8'(16'd255 / slices);
              mode   = MODE_FADE;
            end
          endcase
        end
        KIND_LEVEL: bright = lvl;
        KIND_TICK: begin
          if (mode != MODE_STEADY && (now - last_ms) > {16'd0, interval}) begin
            last_ms = now;
            did     = 1'b1;
            case (mode)
              MODE_BLINK: begin
                bright   = blink_hi ? 8'd255 : 8'd0;
                blink_hi = ~blink_hi;
                recolor();
              end
              MODE_BREATHE: begin
                idx    = (32'(phase) * WAVE_N) >> PHASE_N;
                bright = breathe_lut[idx];
                phase  = phase + phase_inc;
                recolor();
              end
              default: begin
                if (bright > step) begin
                  bright = bright - step;
                  recolor();
                end else begin
                  go_steady(3'd0);
                end
              end
            endcase
          end
        end
        default: ;
      endcase
      want.red        = duty[0];
      want.green      = duty[1];
      want.blue       = duty[2];
      want.refreshed  = did;
      want.brightness = bright;
      want.mode       = mode;
      expected_q.push_back(want);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    // Compare one response with the oldest pending snapshot
    function void check_result(duty_snap_t got);
      duty_snap_t want;
      checked++;
      if (expected_q.size() == 0) begin
        flag($sformatf("response with nothing pending: rgb %0d/%0d/%0d bright %0d mode %0d",
                       got.red, got.green, got.blue, got.brightness, got.mode));
        return;
      end
      want = expected_q.pop_front();
      if (want.refreshed) recomputed++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.refreshed !== want.refreshed || got.brightness !== want.brightness ||
          got.mode !== want.mode)
        flag($sformatf({"response %0d: exp rgb %0d/%0d/%0d refr %0b bright %0d mode %0d,",
                        " got rgb %0d/%0d/%0d refr %0b bright %0d mode %0d"},
                       checked, want.red, want.green, want.blue, want.refreshed,
                       want.brightness, want.mode, got.red, got.green, got.blue,
                       got.refreshed, got.brightness, got.mode));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  rlee_req_if req_ch ();
  rlee_rsp_if rsp_ch ();

  rgb_led_effect_engine DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  led_scoreboard sb;
  bit            src_idle;
  bit            sink_idle;
  int unsigned   hold_cycles;
  int unsigned   n_sent;
  int unsigned   n_phases;
  logic [31:0]   tick_ms;
  duty_snap_t    got_snap;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: check each transaction, then, while sink_idle is set, hold ready low for a random stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_snap.red        = rsp_ch.red_duty;
        got_snap.green      = rsp_ch.green_duty;
        got_snap.blue       = rsp_ch.blue_duty;
        got_snap.refreshed  = rsp_ch.refreshed;
        got_snap.brightness = rsp_ch.brightness;
        got_snap.mode       = mode_t'(rsp_ch.effect_mode);
        sb.check_result(got_snap);
        hold_cycles = sink_idle ? $urandom_range(0, 7) : 0;
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Two-phase APB write; the idle cycle after it keeps psel edges apart
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // Offer one request, after a random gap while src_idle is set, and hold it until accepted
  task automatic send_item(input kind_t k, input logic [31:0] now, input logic [7:0] lvl);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.kind   <= k;
    req_ch.now_ms <= now;
    req_ch.level  <= lvl;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_item(k, now, lvl);
    if (k != KIND_NONE) n_sent++;
  endtask

  // Stop sending and wait until every pending response has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Advance the millisecond clock around the interval so expiry is hit and missed
  task automatic send_tick();
    int unsigned r;
    logic [31:0] iv;
    iv = {16'd0, sb.interval};
    r  = $urandom_range(0, 99);
    if (r < 55) tick_ms = tick_ms + iv + $urandom_range(1, 4);
    else if (r < 70) tick_ms = tick_ms + iv;
    else if (r < 88) tick_ms = tick_ms + $urandom_range(0, iv);
    else if (r < 95) tick_ms = tick_ms + $urandom;
    else tick_ms = 32'hFFFF_FFFF - $urandom_range(0, iv);
    send_item(KIND_TICK, tick_ms, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_level();
    int unsigned r;
    logic [7:0]  lvl;
    r = $urandom_range(0, 99);
    if (r < 15) lvl = 8'd0;
    else if (r < 30) lvl = 8'd255;
    else lvl = 8'($urandom_range(0, 255));
    send_item(KIND_LEVEL, $urandom, lvl);
  endtask

  // Pick a new register setting, extremes included, and load the effect and a random subset of the other registers
  task automatic new_setting();
    int unsigned r;
    logic [15:0] iv;
    logic [15:0] ps;
    logic [15:0] ft;
    r = $urandom_range(0, 99);
    if (r < 40) iv = 16'($urandom_range(1, 8));
    else if (r < 70) iv = 16'($urandom_range(9, 200));
    else if (r < 80) iv = 16'd0;
    else if (r < 90) iv = 16'hFFFF;
    else iv = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 10) ps = 16'd0;
    else if (r < 20) ps = 16'hFFFF;
    else ps = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 40) ft = 16'(32'(iv) * $urandom_range(1, 20));
    else if (r < 60) ft = 16'd0;
    else if (r < 70) ft = 16'hFFFF;
    else ft = 16'($urandom_range(0, 65535));
    write_reg(REG_EFFECT, 32'($urandom_range(0, 3)));
    if ($urandom_range(0, 3) != 0) write_reg(REG_COLOR, 32'($urandom_range(0, 7)));
    if ($urandom_range(0, 3) != 0) write_reg(REG_INTERVAL, 32'(iv));
    if ($urandom_range(0, 3) != 0) write_reg(REG_PHASE, 32'(ps));
    if ($urandom_range(0, 3) != 0) write_reg(REG_FADE, 32'(ft));
  endtask

  initial begin
    int unsigned r;
    int unsigned len;
    sb            = new();
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_ch.valid  = 1'b0;
    req_ch.kind   = KIND_TICK;
    req_ch.now_ms = 32'd0;
    req_ch.level  = 8'd0;
    rsp_ch.ready  = 1'b0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    n_sent        = 0;
    n_phases      = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: steady ticks, level extremes, unused kind, steady start in black
    send_item(KIND_TICK, 32'hFFFF_FFFF, 8'hFF);
    send_item(KIND_LEVEL, 32'h0000_0000, 8'h00);
    send_item(KIND_LEVEL, 32'hFFFF_FFFF, 8'hFF);
    send_item(KIND_NONE, 32'hFFFF_FFFF, 8'hFF);
    send_item(KIND_START, 32'h0000_0000, 8'h00);

    // Blink in the unused color with a zero interval; equal time does not expire
    drain();
    write_reg(REG_EFFECT, 32'(MODE_BLINK));
    write_reg(REG_COLOR, 32'd7);
    send_item(KIND_START, 32'd0, 8'd0);
    send_item(KIND_TICK, 32'd0, 8'd0);
    send_item(KIND_TICK, 32'd1, 8'd0);
    send_item(KIND_TICK, 32'd2, 8'd0);

    // Fade with a zero interval saturates the step and ends at once
    drain();
    write_reg(REG_EFFECT, 32'(MODE_FADE));
    write_reg(REG_FADE, 32'hFFFF);
    send_item(KIND_START, 32'd0, 8'd0);
    send_item(KIND_TICK, 32'd3, 8'd0);

    // Breathe at the largest interval and phase step, with a wrap of the clock
    drain();
    write_reg(REG_EFFECT, 32'(MODE_BREATHE));
    write_reg(REG_COLOR, 32'd2);
    write_reg(REG_INTERVAL, 32'hFFFF);
    write_reg(REG_PHASE, 32'hFFFF);
    send_item(KIND_START, 32'd0, 8'd0);
    send_item(KIND_TICK, 32'd65538, 8'd0);
    send_item(KIND_TICK, 32'd65539, 8'd0);
    send_item(KIND_TICK, 32'hFFFF_FFF0, 8'd0);
    send_item(KIND_TICK, 32'h0000_FFFF, 8'd0);

    // Fade in steps of 25 down to the drop to steady black
    drain();
    write_reg(REG_EFFECT, 32'(MODE_FADE));
    write_reg(REG_INTERVAL, 32'd5);
    write_reg(REG_FADE, 32'd50);
    send_item(KIND_LEVEL, 32'd0, 8'd60);
    send_item(KIND_START, 32'd0, 8'd0);
    send_item(KIND_TICK, 32'h0002_0000, 8'd0);
    send_item(KIND_TICK, 32'h0002_0006, 8'd0);
    send_item(KIND_TICK, 32'h0002_000C, 8'd0);
    tick_ms = 32'h0002_000C;

    // Random phases: new setting, start, then mostly ticks with some noise
    while (n_sent < 1350) begin
      drain();
      new_setting();
      n_phases++;
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) send_level();
      send_item(KIND_START, $urandom, 8'($urandom_range(0, 255)));
      len = $urandom_range(15, 60);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 80) send_tick();
        else if (r < 87) send_level();
        else if (r < 92) send_item(KIND_START, $urandom, 8'($urandom_range(0, 255)));
        else if (r < 96) send_item(KIND_NONE, $urandom, 8'($urandom_range(0, 255)));
        else if (r < 98) drain();
        else begin
          tick_ms = $urandom;
          send_item(KIND_TICK, tick_ms, 8'($urandom_range(0, 255)));
        end
      end
    end

    // Let the last responses land, then watch for strays
    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d requests over %0d register settings; %0d responses checked,",
             n_sent, n_phases, sb.checked);
    $display("%0d of them with recomputed duties.", sb.recomputed);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #5_000_000;
    $display("Timeout with %0d responses still pending", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
